/* design/qcnt_pkg.sv */
// ----------------------------------------------------------------------------
// qcnt_pkg: shared types and constants of the quadrature counter
// Port and channel geometry, counter width, command codes and the 4x step
// table used by every decoder lane.
// ----------------------------------------------------------------------------
`default_nettype none

package qcnt_pkg;

  // geometry
  localparam int PORTS             = 5;
  localparam int PIN_W             = 16;
  localparam int CHANNELS_PER_PORT = PIN_W / 2;
  localparam int MAX_CHANNELS      = PORTS * CHANNELS_PER_PORT;
  localparam int CHANNELS          = 40;
  localparam int COUNT_WIDTH       = 16;
  localparam int SEL_W             = 6;
  localparam int OUT_W             = 16;
  localparam int LANE_IDX_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [PIN_W-1:0]       pins_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SEL_W-1:0]       sel_t;
  typedef logic [OUT_W-1:0]       value_t;

  // command codes
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  // per-lane control for one transfer
  typedef struct packed {
    logic step;
    logic clear;
  } lane_ctrl_t;

  // {old pair, new pair} -> step of -1, 0 or +1
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  // counter to reported value: sign extend, then keep the low bits
  function automatic value_t count_to_value(input count_t cnt);
    logic signed [31:0] ext;
    begin
      ext = 32'(signed'(cnt));
      return ext[OUT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* design/qcnt_if.sv */
// ----------------------------------------------------------------------------
// qcnt_if: valid/ready channels of the quadrature counter
// Sample channel carrying command, five port samples and the read select;
// result channel carrying the selected counter value.
// ----------------------------------------------------------------------------
`default_nettype none

interface qcnt_in_if import qcnt_pkg::*;
  ;
  logic   valid;
  logic   ready;
  logic   command;
  pins_t  port_b_pins;
  pins_t  port_c_pins;
  pins_t  port_d_pins;
  pins_t  port_e_pins;
  pins_t  port_f_pins;
  sel_t   read_channel;

  modport source (
    output valid, command, port_b_pins, port_c_pins, port_d_pins,
    output port_e_pins, port_f_pins, read_channel,
    input  ready
  );
  modport sink (
    input  valid, command, port_b_pins, port_c_pins, port_d_pins,
    input  port_e_pins, port_f_pins, read_channel,
    output ready
  );
endinterface

interface qcnt_out_if import qcnt_pkg::*;
  ;
  logic   valid;
  logic   ready;
  value_t counter_value;

  modport source (output valid, counter_value, input ready);
  modport sink (input valid, counter_value, output ready);
endinterface

`default_nettype wire

/* design/qcnt_lane.sv */
// ----------------------------------------------------------------------------
// qcnt_lane: one quadrature decoder lane
// Looks up the step for the old and new pin pair and keeps the channel's
// wrapping position counter. Offers the post-transfer count to the merge.
// ----------------------------------------------------------------------------
`default_nettype none

module qcnt_lane import qcnt_pkg::*; (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var lane_ctrl_t ctrl_i,
  input  var logic [1:0] old_pair_i,
  input  var logic [1:0] new_pair_i,
  output count_t         count_o
);

  count_t            count_q, count_d;
  logic signed [1:0] step;
  count_t            step_ext;

  // 4x decode: double transitions and no change give zero
  assign step     = STEP_TABLE[{old_pair_i, new_pair_i}];
  assign step_ext = {{(COUNT_WIDTH-2){step[1]}}, step};

  // counter next value
  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.step) begin
      count_d = count_q + step_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

endmodule

`default_nettype wire

/* design/qcnt_merge.sv */
// ----------------------------------------------------------------------------
// qcnt_merge: lane select and result register
// Picks the requested lane's post-transfer count and holds it in the output
// register until the result transfer; absent channels report zero.
// ----------------------------------------------------------------------------
`default_nettype none

module qcnt_merge import qcnt_pkg::*; (
  input  var logic   clk_i,
  input  var logic   rst_ni,
  input  var logic   accept_i,
  input  var sel_t   sel_i,
  input  var count_t lane_count_i [CHANNELS],
  output logic       in_ready_o,
  qcnt_out_if.source out_o
);

  logic   out_valid_q, out_valid_d;
  value_t out_value_q, out_value_d;
  value_t picked;

  // lane select
  always_comb begin
    picked = '0;
    if (32'(sel_i) < CHANNELS) begin
      picked = count_to_value(lane_count_i[sel_i[LANE_IDX_W-1:0]]);
    end
  end

  // output register: takes a new result whenever it is empty or drained
  assign in_ready_o = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    if (accept_i) begin
      out_valid_d = 1'b1;
      out_value_d = picked;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.counter_value = out_value_q;

endmodule

`default_nettype wire

/* design/multi_channel_quadrature_counter_top.sv */
// ----------------------------------------------------------------------------
// multi_channel_quadrature_counter_top: forty-channel 4x quadrature counter
// Stores the last sample of each port, runs one decoder lane per channel and
// returns the selected channel's count for every sample transfer.
// ----------------------------------------------------------------------------
// Throughput is one item per clock while results are taken: every channel has
// its own decoder lane and counter, so a whole sample of all five ports is
// decoded and counted in the cycle it is accepted, and the result appears in
// the output register on the next cycle. The input stays ready while that
// register is empty or being drained, so back-pressure on the result side
// stalls the input only when a result is held. A clear command zeros all
// counters and stored port samples and returns zero.
`default_nettype none

module multi_channel_quadrature_counter_top import qcnt_pkg::*; (
  input  var logic  clk_i,
  input  var logic  rst_ni,
  qcnt_in_if.sink   in_i,
  qcnt_out_if.source out_o
);

  logic       accept;
  logic       in_ready;
  logic       is_clear;
  lane_ctrl_t lane_ctrl;
  pins_t      now_pins [PORTS];
  pins_t      prev_q   [PORTS];
  pins_t      prev_d   [PORTS];
  count_t     lane_count [CHANNELS];

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign is_clear   = (in_i.command == CMD_CLEAR);

  assign lane_ctrl.step  = accept && !is_clear;
  assign lane_ctrl.clear = accept && is_clear;

  assign now_pins[0] = in_i.port_b_pins;
  assign now_pins[1] = in_i.port_c_pins;
  assign now_pins[2] = in_i.port_d_pins;
  assign now_pins[3] = in_i.port_e_pins;
  assign now_pins[4] = in_i.port_f_pins;

  // stored port samples
  always_comb begin
    for (int p = 0; p < PORTS; p++) begin
      prev_d[p] = prev_q[p];
      if (lane_ctrl.clear) begin
        prev_d[p] = '0;
      end else if (lane_ctrl.step) begin
        prev_d[p] = now_pins[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PORTS; p++) begin
        prev_q[p] <= '0;
      end
    end else begin
      prev_q <= prev_d;
    end
  end

  // one decoder lane per channel: pins 2k and 2k+1 of port p
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    localparam int P = ch / CHANNELS_PER_PORT;
    localparam int K = ch % CHANNELS_PER_PORT;

    qcnt_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .old_pair_i (prev_q[P][2*K +: 2]),
      .new_pair_i (now_pins[P][2*K +: 2]),
      .count_o    (lane_count[ch])
    );
  end

  // select and result register
  qcnt_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .sel_i        (in_i.read_channel),
    .lane_count_i (lane_count),
    .in_ready_o   (in_ready),
    .out_o        (out_o)
  );

`ifndef NO_ASSERTIONS
  // a clear transfer reports zero in the next cycle
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl.clear |=> (out_o.valid && out_o.counter_value == '0))
    else $error("clear did not report a zero count");

  // a clear transfer wipes the stored samples
  a_clear_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl.clear |=> (prev_q[0] == '0 && prev_q[PORTS-1] == '0))
    else $error("stored samples survived a clear");

  // a sample transfer is stored for the next decode
  a_sample_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl.step |=> (prev_q[0] == $past(in_i.port_b_pins)
                        && prev_q[PORTS-1] == $past(in_i.port_f_pins)))
    else $error("port sample not stored");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the forty-channel quadrature counter
// Drives sample and clear transfers with random gaps, keeps its own decoder
// of every channel, and checks each returned count against the oldest
// outstanding prediction. Covers clears, absent channels, double
// transitions, backward motion through zero, and a one-way sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import qcnt_pkg::*;;

  localparam int QUIET_LIMIT  = 5000;
  localparam int LONG_HOLD    = 300;
  localparam int SWEEP_STEPS  = 150;

  // one sample transfer: port 0 (b) in pins[0] up to port 4 (f) in pins[4]
  typedef struct packed {
    cmd_e                  command;
    pins_t [PORTS-1:0]     pins;
    sel_t                  read_channel;
  } sample_t;

  logic clk;
  logic rst_n = 1'b0;

  logic    drv_valid  = 1'b0;
  sample_t drv_item   = '0;
  logic    take_ready = 1'b0;

  sample_t pending_samples[$];
  value_t  expected_counts[$];

  // decoder state kept by the bench
  pins_t  model_pins  [PORTS];
  count_t model_count [MAX_CHANNELS];
  // last pins queued, used to build well-formed motion
  pins_t  gen_pins    [PORTS];

  int send_gap     = 0;
  int recv_gap     = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  qcnt_in_if  sample_ch ();
  qcnt_out_if count_ch ();

  assign sample_ch.valid        = drv_valid;
  assign sample_ch.command      = drv_item.command;
  assign sample_ch.port_b_pins  = drv_item.pins[0];
  assign sample_ch.port_c_pins  = drv_item.pins[1];
  assign sample_ch.port_d_pins  = drv_item.pins[2];
  assign sample_ch.port_e_pins  = drv_item.pins[3];
  assign sample_ch.port_f_pins  = drv_item.pins[4];
  assign sample_ch.read_channel = drv_item.read_channel;
  assign count_ch.ready         = take_ready;

  multi_channel_quadrature_counter_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (sample_ch),
    .out_o  (count_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one forward quadrature step of a pin pair
  function automatic logic [1:0] quad_up(logic [1:0] pair);
    case (pair)
      2'b00:   return 2'b10;
      2'b10:   return 2'b11;
      2'b11:   return 2'b01;
      default: return 2'b00;
    endcase
  endfunction

  // one backward quadrature step of a pin pair
  function automatic logic [1:0] quad_down(logic [1:0] pair);
    case (pair)
      2'b00:   return 2'b01;
      2'b01:   return 2'b11;
      2'b11:   return 2'b10;
      default: return 2'b00;
    endcase
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // decode one accepted sample and return the selected count
  function automatic value_t decode_sample(sample_t s);
    int ch;
    logic [1:0] was;
    logic [1:0] now;
    logic signed [31:0] wide;
    if (s.command == CMD_CLEAR) begin
      for (int p = 0; p < PORTS; p++) model_pins[p] = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) model_count[c] = '0;
    end else begin
      for (int p = 0; p < PORTS; p++) begin
        for (int k = 0; k < CHANNELS_PER_PORT; k++) begin
          ch = p * CHANNELS_PER_PORT + k;
          if (ch < CHANNELS) begin
            was = model_pins[p][2*k +: 2];
            now = s.pins[p][2*k +: 2];
            if (now == quad_up(was)) model_count[ch] = model_count[ch] + 1'b1;
            else if (now == quad_down(was)) model_count[ch] = model_count[ch] - 1'b1;
          end
        end
        model_pins[p] = s.pins[p];
      end
    end
    if (int'(s.read_channel) >= CHANNELS) return '0;
    wide = 32'(signed'(model_count[s.read_channel]));
    return wide[OUT_W-1:0];
  endfunction

  // queue a tick with the given pins on each port
  task automatic queue_tick(pins_t [PORTS-1:0] pins, int sel);
    sample_t s;
    s.command      = CMD_TICK;
    s.pins         = pins;
    s.read_channel = sel_t'(sel);
    for (int p = 0; p < PORTS; p++) gen_pins[p] = pins[p];
    pending_samples.push_back(s);
  endtask

  // queue a clear; its port values are noise
  task automatic queue_clear(int sel);
    sample_t s;
    s.command      = CMD_CLEAR;
    s.read_channel = sel_t'(sel);
    for (int p = 0; p < PORTS; p++) begin
      s.pins[p]   = pins_t'($urandom);
      gen_pins[p] = '0;
    end
    pending_samples.push_back(s);
  endtask

  // random motion: per channel a forward, backward, held or noisy pair
  task automatic queue_motion(int n, int up_pct, int down_pct, int noise_pct,
                              int clear_pct);
    pins_t [PORTS-1:0] pins;
    logic [1:0] pair;
    int r;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 39);
      if ($urandom_range(0, 99) < clear_pct) begin
        queue_clear(sel);
      end else begin
        for (int p = 0; p < PORTS; p++) begin
          for (int k = 0; k < CHANNELS_PER_PORT; k++) begin
            pair = gen_pins[p][2*k +: 2];
            r = $urandom_range(0, 99);
            if (r < noise_pct) pair = 2'($urandom);
            else if (r < noise_pct + up_pct) pair = quad_up(pair);
            else if (r < noise_pct + up_pct + down_pct) pair = quad_down(pair);
            pins[p][2*k +: 2] = pair;
          end
        end
        queue_tick(pins, sel);
      end
    end
  endtask

  // hold off until every queued item has gone through and been checked
  task automatic wait_drained();
    while (pending_samples.size() != 0 || drv_valid || expected_counts.size() != 0)
      @(posedge clk);
  endtask

  // sample driver
  always @(posedge clk) begin : drive_samples
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && sample_ch.ready) begin
        expected_counts.push_back(decode_sample(drv_item));
      end
      if (!drv_valid || sample_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          drv_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          drv_item  <= pending_samples.pop_front();
          drv_valid <= 1'b1;
          items_sent++;
          send_gap = pick_gap((items_sent % 200) >= 150);
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : check_counts
    value_t want;
    if (!rst_n) begin
      take_ready <= 1'b0;
    end else begin
      if (count_ch.valid && take_ready) begin
        if (expected_counts.size() == 0) begin
          if (mismatches < 10)
            $display("tb_top: unexpected count transfer, got %h", count_ch.counter_value);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (count_ch.counter_value !== want) begin
            if (mismatches < 10)
              $display("tb_top: count mismatch at result %0d: expected %h, got %h",
                       results_seen, want, count_ch.counter_value);
            mismatches++;
          end
        end
        results_seen++;
        // long hold-off so the block fills and stalls its input
        if (results_seen == 500 || results_seen == 1200) recv_gap = LONG_HOLD;
        else recv_gap = pick_gap((results_seen % 256) < 48);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  // count cycles without any transfer
  always @(posedge clk) begin
    if ((drv_valid && sample_ch.ready) || (count_ch.valid && take_ready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // reset and stimulus
  initial begin
    for (int p = 0; p < PORTS; p++) begin
      model_pins[p] = '0;
      gen_pins[p]   = '0;
    end
    for (int c = 0; c < MAX_CHANNELS; c++) model_count[c] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: backward turn, forward turn, double transitions
    queue_tick({PORTS{16'h0000}}, 0);
    queue_tick({PORTS{16'h5555}}, 0);
    queue_tick({PORTS{16'hFFFF}}, 39);
    queue_tick({PORTS{16'hAAAA}}, 8);
    queue_tick({PORTS{16'h0000}}, 63);
    queue_tick({PORTS{16'hAAAA}}, 40);
    queue_tick({PORTS{16'hFFFF}}, 16);
    queue_tick({PORTS{16'h5555}}, 24);
    queue_tick({PORTS{16'h0000}}, 32);
    queue_tick({PORTS{16'hFFFF}}, 7);
    queue_tick({PORTS{16'h0000}}, 15);
    queue_tick({PORTS{16'hCCCC}}, 1);
    queue_tick({PORTS{16'h3333}}, 23);
    queue_tick({PORTS{16'h5555}}, 31);
    queue_tick({16'h1234, 16'hFF00, 16'h00FF, 16'h8000, 16'h0001}, 33);
    // clear ignores ports and zeros the stored samples
    queue_clear(39);
    queue_tick({PORTS{16'hFFFF}}, 0);
    queue_tick({PORTS{16'h5555}}, 1);
    queue_clear(63);
    queue_tick({PORTS{16'h5555}}, 5);
    queue_tick({PORTS{16'h0000}}, 20);
    queue_tick({PORTS{16'h0002}}, 32);
    wait_drained();

    // random motion, mostly well-formed
    queue_motion(750, 40, 40, 5, 2);
    wait_drained();

    // one-way sweep that steps every counter forward on each sample
    queue_clear($urandom_range(0, 39));
    queue_motion(SWEEP_STEPS, 100, 0, 0, 0);

    // drifting random motion
    queue_motion(750, 60, 15, 5, 2);
    wait_drained();
    repeat (5) @(posedge clk);

    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
